// ===== hw/rtl/nss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg: neighbor subgraph signature shared definitions
// Widths, reset values, sequencer states, bit count and mask helpers.
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int unsigned ROW_W             = 64;
    localparam int unsigned IDX_FIELD_W       = 6;
    localparam int unsigned ATOM_COUNT_W      = 7;
    localparam int unsigned EDGE_COUNT_W      = 11;
    localparam int unsigned PATH_W            = 6;
    localparam int unsigned MAX_ATOMS_DEFAULT = 64;

    localparam logic [ATOM_COUNT_W-1:0] ATOM_COUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NBR,
        S_EDGE,
        S_SRC,
        S_BFS,
        S_OUT
    } nss_state_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + {3'b000, v[i]};
        end
        return s;
    endfunction

    function automatic logic [6:0] popcount64(input logic [ROW_W-1:0] v);
        logic [6:0] s;
        s = '0;
        for (int k = 0; k < ROW_W / 8; k++)
        begin
            s = s + {3'b000, popcount8(v[k*8 +: 8])};
        end
        return s;
    endfunction

    function automatic logic [ROW_W-1:0] low_mask(input logic [ATOM_COUNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        if (n >= ATOM_COUNT_W'(ROW_W))
        begin
            m = '1;
        end
        else
        begin
            m = (ROW_W'(1) << n) - ROW_W'(1);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/neighbor_subgraph_signature_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_subgraph_signature_unit: neighbor subgraph signature of one atom
// Row store, neighbor scan, edge count and bitset breadth-first search.
// ----------------------------------------------------------------------------
// Each accepted input beat with row_index below MAX_ATOMS writes one
// adjacency row. A beat with last_row set then starts a job that scans the
// row store through its single registered read port, one row per cycle. With
// n the atom count in use, capped at MAX_ATOMS, the job runs a neighbor scan,
// an edge count scan and a walk over the source slots. Each neighbor adds one
// breadth-first search of (hops + 1) full scans, hops being its largest
// distance and the last scan being the one that finds nothing new. The S_OUT
// state then moves the result into the output register. The input is stalled
// for the whole job. Rows that follow are taken while the result beat waits;
// a finished job waits only while the previous result is still held.
module neighbor_subgraph_signature_unit #(
    parameter int unsigned MAX_ATOMS = nss_pkg::MAX_ATOMS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [nss_pkg::ATOM_COUNT_W-1:0]     cfg_wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [nss_pkg::IDX_FIELD_W-1:0]      row_index,
    input  wire logic [nss_pkg::ROW_W-1:0]            row_bits,
    input  wire logic [nss_pkg::IDX_FIELD_W-1:0]      center_atom,
    input  wire logic                                 last_row,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [nss_pkg::ATOM_COUNT_W-1:0]          neighbor_count,
    output logic [nss_pkg::EDGE_COUNT_W-1:0]          neighbor_edge_count,
    output logic [nss_pkg::PATH_W-1:0]                path_span,
    output logic                                      unreachable
);

    import nss_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ATOMS);
    localparam int unsigned CNT_W = $clog2(MAX_ATOMS + 1);

    logic [ROW_W-1:0] adj_mem [MAX_ATOMS];
    logic [ROW_W-1:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_wr_en;

    nss_state_t state_reg, state_next;

    logic [ATOM_COUNT_W-1:0] atom_count_reg;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [ROW_W-1:0]        cols_reg, cols_next;
    logic [IDX_FIELD_W-1:0]  center_reg, center_next;
    logic                    center_ok_reg, center_ok_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pidx_reg, pidx_next;
    logic [CNT_W-1:0]        src_reg, src_next;
    logic [ROW_W-1:0]        nbr_reg, nbr_next;
    logic [ROW_W-1:0]        visited_reg, visited_next;
    logic [ROW_W-1:0]        frontier_reg, frontier_next;
    logic [ROW_W-1:0]        next_reg, next_next;
    logic [PATH_W-1:0]       dist_reg, dist_next;
    logic [PATH_W-1:0]       longest_reg, longest_next;
    logic                    unreach_reg, unreach_next;
    logic [ATOM_COUNT_W-1:0] count_reg, count_next;
    logic [EDGE_COUNT_W-1:0] edges_reg, edges_next;

    logic                    out_valid_reg;
    logic [ATOM_COUNT_W-1:0] res_count_reg;
    logic [EDGE_COUNT_W-1:0] res_edges_reg;
    logic [PATH_W-1:0]       res_path_reg;
    logic                    res_unreach_reg;

    logic             in_accept;
    logic             issue;
    logic             scan_done;
    logic             out_load;
    logic [ROW_W-1:0] upper;
    logic [ROW_W-1:0] u_row;
    logic [ROW_W-1:0] reach;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mem_wr_en = in_accept && (int'(row_index) < MAX_ATOMS);
    assign out_valid = out_valid_reg;

    assign neighbor_count      = res_count_reg;
    assign neighbor_edge_count = res_edges_reg;
    assign path_span           = res_path_reg;
    assign unreachable         = res_unreach_reg;

    // row store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            adj_mem[row_index[IDX_W-1:0]] <= row_bits;
        end
        rdata_reg <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= ATOM_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            atom_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_count_reg   <= count_reg;
            res_edges_reg   <= edges_reg;
            res_path_reg    <= longest_reg;
            res_unreach_reg <= unreach_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        cols_reg      <= cols_next;
        center_reg    <= center_next;
        center_ok_reg <= center_ok_next;
        pidx_reg      <= pidx_next;
        src_reg       <= src_next;
        nbr_reg       <= nbr_next;
        visited_reg   <= visited_next;
        frontier_reg  <= frontier_next;
        next_reg      <= next_next;
        dist_reg      <= dist_next;
        longest_reg   <= longest_next;
        unreach_reg   <= unreach_next;
        count_reg     <= count_next;
        edges_reg     <= edges_next;
    end

    // upper-triangle bonds of the row in flight, restricted to neighbors
    always_comb
    begin
        upper = ~((ROW_W'(2) << pidx_reg) - ROW_W'(1));
        u_row = nbr_reg[pidx_reg] ? (rdata_reg & cols_reg & nbr_reg & upper) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cols_next      = cols_reg;
        center_next    = center_reg;
        center_ok_next = center_ok_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        src_next       = src_reg;
        nbr_next       = nbr_reg;
        visited_next   = visited_reg;
        frontier_next  = frontier_reg;
        next_next      = next_reg;
        dist_next      = dist_reg;
        longest_next   = longest_reg;
        unreach_next   = unreach_reg;
        count_next     = count_reg;
        edges_next     = edges_reg;
        out_load       = 1'b0;
        reach          = next_reg & ~visited_reg;

        issue     = (cnt_reg < n_reg);
        scan_done = !issue && !pend_reg;
        rd_addr   = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && last_row)
                begin
                    if (atom_count_reg > ATOM_COUNT_W'(MAX_ATOMS))
                    begin
                        n_next    = CNT_W'(MAX_ATOMS);
                        cols_next = low_mask(ATOM_COUNT_W'(MAX_ATOMS));
                    end
                    else
                    begin
                        n_next    = CNT_W'(atom_count_reg);
                        cols_next = low_mask(atom_count_reg);
                    end
                    center_next    = center_atom;
                    center_ok_next = ({1'b0, center_atom} < atom_count_reg)
                                     && (int'(center_atom) < MAX_ATOMS);
                    nbr_next       = '0;
                    count_next     = '0;
                    cnt_next       = '0;
                    state_next     = S_NBR;
                end
            end

            S_NBR:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg && center_ok_reg && rdata_reg[center_reg])
                begin
                    nbr_next[pidx_reg] = 1'b1;
                    count_next         = count_reg + ATOM_COUNT_W'(1);
                end
                if (scan_done)
                begin
                    cnt_next   = '0;
                    edges_next = '0;
                    state_next = S_EDGE;
                end
            end

            S_EDGE:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    edges_next = edges_reg + EDGE_COUNT_W'(popcount64(u_row));
                end
                if (scan_done)
                begin
                    src_next     = '0;
                    longest_next = '0;
                    unreach_next = 1'b0;
                    state_next   = S_SRC;
                end
            end

            S_SRC:
            begin
                if (src_reg == n_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    src_next = src_reg + CNT_W'(1);
                    if (nbr_reg[src_reg[IDX_W-1:0]])
                    begin
                        visited_next  = ROW_W'(1) << src_reg[IDX_W-1:0];
                        frontier_next = ROW_W'(1) << src_reg[IDX_W-1:0];
                        next_next     = '0;
                        dist_next     = '0;
                        cnt_next      = '0;
                        state_next    = S_BFS;
                    end
                end
            end

            S_BFS:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (frontier_reg[pidx_reg])
                    begin
                        next_next = next_next | u_row;
                    end
                    if (|(u_row & frontier_reg))
                    begin
                        next_next[pidx_reg] = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    if (reach == '0)
                    begin
                        if (dist_reg > longest_reg)
                        begin
                            longest_next = dist_reg;
                        end
                        if (visited_reg != nbr_reg)
                        begin
                            unreach_next = 1'b1;
                        end
                        state_next = S_SRC;
                    end
                    else
                    begin
                        dist_next     = dist_reg + PATH_W'(1);
                        visited_next  = visited_reg | reach;
                        frontier_next = reach;
                        next_next     = '0;
                        cnt_next      = '0;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
